/* rtl/core/sic_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the segment intersection cosine unit.
// No dependencies.
package sic_pkg;

  // result classes
  typedef logic [2:0] class_t;
  localparam class_t CLS_NONE     = 3'd0;
  localparam class_t CLS_PARALLEL = 3'd1;
  localparam class_t CLS_DEGEN    = 3'd2;
  localparam class_t CLS_SHARED   = 3'd3;
  localparam class_t CLS_CROSS    = 3'd4;

  // how the final cosine is formed from the quotient magnitude
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ZERO = 2'd0;
  localparam mode_t MODE_ONE  = 2'd1;
  localparam mode_t MODE_POS  = 2'd2;
  localparam mode_t MODE_NEG  = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PAR_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINY    = 2'd2;

  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] PAR_TOL_RST = 16'd364;
  localparam logic [CFG_W-1:0] CLOSE_RST   = 16'd655;
  localparam logic [CFG_W-1:0] TINY_RST    = 16'd1;

  localparam int FRAC_BITS = 16;
  localparam int QUO_BITS  = 17;
  localparam int COS_W     = 18;
  localparam logic [QUO_BITS-1:0] COS_ONE = 17'h10000;

  // control that rides along with the divider
  typedef struct packed {
    class_t cls;
    mode_t  mode;
    logic   sat;
  } ctl_t;

endpackage

/* rtl/core/sic_isqrt2.sv */
`timescale 1ns / 1ps
// Two-lane pipelined integer square root, one root bit per stage.
// Carries an opaque sideband vector alongside. No package dependencies.
module sic_isqrt2 #(
  parameter int RW = 33,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_v,
  input  logic [2*RW-1:0] xa,
  input  logic [2*RW-1:0] xb,
  input  logic [SW-1:0]   side_in,
  output logic            out_v,
  output logic [RW-1:0]   ra,
  output logic [RW-1:0]   rb,
  output logic [SW-1:0]   side_out
);

  logic            vld   [RW+1];
  logic [2*RW-1:0] xa_s  [RW+1];
  logic [2*RW-1:0] xb_s  [RW+1];
  logic [RW+1:0]   rema  [RW+1];
  logic [RW+1:0]   remb  [RW+1];
  logic [RW-1:0]   roota [RW+1];
  logic [RW-1:0]   rootb [RW+1];
  logic [SW-1:0]   side  [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_s[0]  <= xa;
      xb_s[0]  <= xb;
      rema[0]  <= '0;
      remb[0]  <= '0;
      roota[0] <= '0;
      rootb[0] <= '0;
      side[0]  <= side_in;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0] ta, tra, tb, trb;

    // bring down the next two radicand bits, trial subtract 4*root+1
    assign ta  = {rema[i][RW-1:0], xa_s[i][2*RW-1 -: 2]};
    assign tra = {roota[i], 2'b01};
    assign tb  = {remb[i][RW-1:0], xb_s[i][2*RW-1 -: 2]};
    assign trb = {rootb[i], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (ta >= tra) begin
          rema[i+1]  <= ta - tra;
          roota[i+1] <= {roota[i][RW-2:0], 1'b1};
        end else begin
          rema[i+1]  <= ta;
          roota[i+1] <= {roota[i][RW-2:0], 1'b0};
        end
        if (tb >= trb) begin
          remb[i+1]  <= tb - trb;
          rootb[i+1] <= {rootb[i][RW-2:0], 1'b1};
        end else begin
          remb[i+1]  <= tb;
          rootb[i+1] <= {rootb[i][RW-2:0], 1'b0};
        end
        xa_s[i+1] <= xa_s[i] << 2;
        xb_s[i+1] <= xb_s[i] << 2;
        side[i+1] <= side[i];
      end
    end
  end

  assign out_v    = vld[RW];
  assign ra       = roota[RW];
  assign rb       = rootb[RW];
  assign side_out = side[RW];

endmodule

/* rtl/core/sic_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sic_pkg (quotient width, control struct).
module sic_div #(
  parameter int NW = 82,
  parameter int DW = 66
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [NW-1:0]                 num,
  input  logic [DW-1:0]                 den,
  input  sic_pkg::ctl_t                 ctl_in,
  output logic                          out_v,
  output logic [sic_pkg::QUO_BITS-1:0]  quo,
  output sic_pkg::ctl_t                 ctl_out
);
  import sic_pkg::*;

  localparam int QB = QUO_BITS;

  logic          vld [QB+1];
  logic [NW-1:0] rem [QB+1];
  logic [DW-1:0] dv  [QB+1];
  logic [QB-1:0] q   [QB+1];
  ctl_t          ctl [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      q[0]   <= '0;
      ctl[0] <= ctl_in;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int K = QB - 1 - i;
    logic [NW-1:0] dsh;

    assign dsh = NW'(dv[i]) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[i] >= dsh) begin
          rem[i+1] <= rem[i] - dsh;
          q[i+1]   <= {q[i][QB-2:0], 1'b1};
        end else begin
          rem[i+1] <= rem[i];
          q[i+1]   <= {q[i][QB-2:0], 1'b0};
        end
        dv[i+1]  <= dv[i];
        ctl[i+1] <= ctl[i];
      end
    end
  end

  assign out_v   = vld[QB];
  assign quo     = q[QB];
  assign ctl_out = ctl[QB];

endmodule

/* rtl/core/segment_intersection_cosine_unit.sv */
`timescale 1ns / 1ps
// Segment intersection cosine unit, top level.
// Depends on sic_pkg, sic_isqrt2 and sic_div.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one item per cycle while
//   in_stall is low: two segments p1-p2 and q1-q2, signed Q15.16
//   coordinates. Output channel (out_valid / out_stall) delivers one item
//   per input item, in order: result_class and a signed Q1.16 cosine.
//   Config channel (cfg_valid / cfg_ready, always ready) writes the
//   parallel tolerance, closeness ratio and tiny threshold by index.
//   Write config only while the pipeline is empty.
// Throughput: one item per cycle while the output is not stalled.
// Pipeline: the bit-per-stage square root (COORD_BITS + 2 stages) and the
//   bit-per-stage divider (18 stages), plus the product and compare stages.
// Stall: the whole pipeline freezes while out_valid is high and out_stall
//   is asserted; in_stall follows that condition, nothing is dropped.
// Reset: rst (synchronous) clears every valid bit and loads the register
//   defaults: tolerance 364, ratio 655, tiny 1.
module segment_intersection_cosine_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sic_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sic_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         p1_x,
  input  logic signed [COORD_BITS-1:0]         p1_y,
  input  logic signed [COORD_BITS-1:0]         p2_x,
  input  logic signed [COORD_BITS-1:0]         p2_y,
  input  logic signed [COORD_BITS-1:0]         q1_x,
  input  logic signed [COORD_BITS-1:0]         q1_y,
  input  logic signed [COORD_BITS-1:0]         q2_x,
  input  logic signed [COORD_BITS-1:0]         q2_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sic_pkg::class_t                      result_class,
  output logic signed [sic_pkg::COS_W-1:0]     cosine
);
  import sic_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;          // coordinate difference, also root width
  localparam int W2 = 2 * D;          // magnitude of squares and products
  localparam int P  = 2 * D + 1;      // signed sum of two products
  localparam int NW = W2 + FRAC_BITS; // scaled numerator

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] par_tol, close_ratio, tiny;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      par_tol     <= PAR_TOL_RST;
      close_ratio <= CLOSE_RST;
      tiny        <= TINY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAR_TOL: par_tol     <= cfg_data;
        REG_CLOSE:   close_ratio <= cfg_data;
        REG_TINY:    tiny        <= cfg_data;
        default: ;
      endcase
    end
  end

  // one enable for every stage: hold all while the result waits
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---------------------------------------------------------------------
  // arithmetic helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [P-1:0] dot2(
    input logic signed [D-1:0] ax, ay, bx, by);
    logic signed [W2-1:0] m1, m2;
    m1 = ax * bx;
    m2 = ay * by;
    return P'(m1) + P'(m2);
  endfunction

  function automatic logic signed [P-1:0] cross2(
    input logic signed [D-1:0] ax, ay, bx, by);
    logic signed [W2-1:0] m1, m2;
    m1 = ax * by;
    m2 = ay * bx;
    return P'(m1) - P'(m2);
  endfunction

  function automatic logic [W2-1:0] mag(input logic signed [P-1:0] v);
    logic signed [P-1:0] n;
    n = -v;
    return v[P-1] ? n[W2-1:0] : v[W2-1:0];
  endfunction

  // num / den lies in [0,1]
  function automatic logic in_unit(input logic signed [P-1:0] num, den);
    return (num == '0) || ((num[P-1] == den[P-1]) && (mag(num) <= mag(den)));
  endfunction

  // foot of the perpendicular falls inside the segment
  function automatic logic proj(input logic signed [P-1:0] dt, len);
    return !dt[P-1] && ($unsigned(dt) <= $unsigned(len));
  endfunction

  // point within lim of a segment
  function automatic logic near(input logic tinyd, pj,
                                input logic [W2-1:0] ea, eb, crs, lim2, limroot);
    if (tinyd) return ea <= lim2;
    if (pj) return crs <= limroot;
    return (ea <= lim2) || (eb <= lim2);
  endfunction

  // ---------------------------------------------------------------------
  // stage A: input register
  // ---------------------------------------------------------------------
  logic a_v;
  logic signed [C-1:0] a_p1x, a_p1y, a_p2x, a_p2y, a_q1x, a_q1y, a_q2x, a_q2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p1x <= p1_x; a_p1y <= p1_y; a_p2x <= p2_x; a_p2y <= p2_y;
      a_q1x <= q1_x; a_q1y <= q1_y; a_q2x <= q2_x; a_q2y <= q2_y;
    end
  end

  // ---------------------------------------------------------------------
  // stage B: segment vectors, endpoint differences, shared endpoints
  // ---------------------------------------------------------------------
  logic b_v;
  logic signed [D-1:0] b_rx, b_ry, b_sx, b_sy;
  logic signed [D-1:0] b_f11x, b_f11y, b_f12x, b_f12y;  // p1-q1, p1-q2
  logic signed [D-1:0] b_f21x, b_f21y, b_f22x, b_f22y;  // p2-q1, p2-q2
  logic signed [D-1:0] b_n11x, b_n11y, b_n12x, b_n12y;  // q1-p1, q2-p1
  logic [3:0] b_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_rx   <= D'(a_p2x) - D'(a_p1x);
      b_ry   <= D'(a_p2y) - D'(a_p1y);
      b_sx   <= D'(a_q2x) - D'(a_q1x);
      b_sy   <= D'(a_q2y) - D'(a_q1y);
      b_f11x <= D'(a_p1x) - D'(a_q1x);
      b_f11y <= D'(a_p1y) - D'(a_q1y);
      b_f12x <= D'(a_p1x) - D'(a_q2x);
      b_f12y <= D'(a_p1y) - D'(a_q2y);
      b_f21x <= D'(a_p2x) - D'(a_q1x);
      b_f21y <= D'(a_p2y) - D'(a_q1y);
      b_f22x <= D'(a_p2x) - D'(a_q2x);
      b_f22y <= D'(a_p2y) - D'(a_q2y);
      b_n11x <= D'(a_q1x) - D'(a_p1x);
      b_n11y <= D'(a_q1y) - D'(a_p1y);
      b_n12x <= D'(a_q2x) - D'(a_p1x);
      b_n12y <= D'(a_q2y) - D'(a_p1y);
      // shared-endpoint bits p1q1, p1q2, p2q1, p2q2; p1q1 or p2q2 has priority
      b_eq[0] <= (a_p1x == a_q1x) && (a_p1y == a_q1y);
      b_eq[1] <= (a_p1x == a_q2x) && (a_p1y == a_q2y);
      b_eq[2] <= (a_p2x == a_q1x) && (a_p2y == a_q1y);
      b_eq[3] <= (a_p2x == a_q2x) && (a_p2y == a_q2y);
    end
  end

  // ---------------------------------------------------------------------
  // stage C: squared lengths, dots and crosses
  // Point-to-segment tests: 1) p1 to q1-q2, 2) p2 to q1-q2,
  // 3) q1 to p1-p2, 4) q2 to p1-p2.
  // ---------------------------------------------------------------------
  logic c_v;
  logic signed [P-1:0] c_rr, c_ss, c_b, c_rs, c_c1;
  logic signed [P-1:0] c_d11, c_d12, c_d21, c_d22;
  logic signed [P-1:0] c_dot1, c_dot2, c_dot3, c_dot4;
  logic signed [P-1:0] c_cr1, c_cr2, c_cr3, c_cr4;
  logic [3:0] c_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_rr   <= dot2(b_rx, b_ry, b_rx, b_ry);
      c_ss   <= dot2(b_sx, b_sy, b_sx, b_sy);
      c_b    <= cross2(b_rx, b_ry, b_sx, b_sy);
      c_rs   <= dot2(b_rx, b_ry, b_sx, b_sy);
      c_c1   <= cross2(b_n11x, b_n11y, b_sx, b_sy);
      c_d11  <= dot2(b_f11x, b_f11y, b_f11x, b_f11y);
      c_d12  <= dot2(b_f12x, b_f12y, b_f12x, b_f12y);
      c_d21  <= dot2(b_f21x, b_f21y, b_f21x, b_f21y);
      c_d22  <= dot2(b_f22x, b_f22y, b_f22x, b_f22y);
      c_dot1 <= dot2(b_f11x, b_f11y, b_sx, b_sy);
      c_cr1  <= cross2(b_f11x, b_f11y, b_sx, b_sy);
      c_dot2 <= dot2(b_f21x, b_f21y, b_sx, b_sy);
      c_cr2  <= cross2(b_f21x, b_f21y, b_sx, b_sy);
      c_dot3 <= dot2(b_n11x, b_n11y, b_rx, b_ry);
      c_cr3  <= cross2(b_n11x, b_n11y, b_rx, b_ry);
      c_dot4 <= dot2(b_n12x, b_n12y, b_rx, b_ry);
      c_cr4  <= cross2(b_n12x, b_n12y, b_rx, b_ry);
      c_eq   <= b_eq;
    end
  end

  // ---------------------------------------------------------------------
  // stage D: flags and magnitudes, then the square root pipeline
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [W2-1:0] d11, d12, d21, d22;
    logic [W2-1:0] crs1, crs2, crs3, crs4;
    logic [W2-1:0] babs, rsabs;
    logic          rs_neg;
    logic          tiny_r, tiny_s;
    logic [3:0]    pj;
    logic          cross_ok;
    logic [3:0]    eq;
  } side_t;

  logic [P-1:0] tiny_q;
  side_t d_side, sq_side;
  logic sq_v;
  logic [D-1:0] sq_rn, sq_sn;

  assign tiny_q = P'({tiny, {FRAC_BITS{1'b0}}});

  always_comb begin
    d_side.d11      = c_d11[W2-1:0];
    d_side.d12      = c_d12[W2-1:0];
    d_side.d21      = c_d21[W2-1:0];
    d_side.d22      = c_d22[W2-1:0];
    d_side.crs1     = mag(c_cr1);
    d_side.crs2     = mag(c_cr2);
    d_side.crs3     = mag(c_cr3);
    d_side.crs4     = mag(c_cr4);
    d_side.babs     = mag(c_b);
    d_side.rsabs    = mag(c_rs);
    d_side.rs_neg   = c_rs[P-1];
    d_side.tiny_r   = $unsigned(c_rr) <= tiny_q;
    d_side.tiny_s   = $unsigned(c_ss) <= tiny_q;
    d_side.pj[0]    = proj(c_dot1, c_ss);
    d_side.pj[1]    = proj(c_dot2, c_ss);
    d_side.pj[2]    = proj(c_dot3, c_rr);
    d_side.pj[3]    = proj(c_dot4, c_rr);
    // crossing: (q1-p1) x s / (r x s) and (q1-p1) x r / (r x s) in [0,1]
    d_side.cross_ok = in_unit(c_c1, c_b) && in_unit(c_cr3, c_b);
    d_side.eq       = c_eq;
  end

  sic_isqrt2 #(
    .RW (D),
    .SW ($bits(side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (c_v),
    .xa       (c_rr[W2-1:0]),
    .xb       (c_ss[W2-1:0]),
    .side_in  (d_side),
    .out_v    (sq_v),
    .ra       (sq_rn),
    .rb       (sq_sn),
    .side_out (sq_side)
  );

  // ---------------------------------------------------------------------
  // stage E: closeness limit and length product
  // ---------------------------------------------------------------------
  logic e_v;
  side_t e_side;
  logic [D-1:0] e_rn, e_sn, e_lim, mx;
  logic [W2-1:0] e_lens;
  logic [D+FRAC_BITS-1:0] lim_prod;

  assign mx       = (sq_rn > sq_sn) ? sq_rn : sq_sn;
  assign lim_prod = (D+FRAC_BITS)'(mx) * (D+FRAC_BITS)'(close_ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side <= sq_side;
      e_rn   <= sq_rn;
      e_sn   <= sq_sn;
      e_lim  <= lim_prod[D+FRAC_BITS-1:FRAC_BITS];
      e_lens <= W2'(sq_rn) * W2'(sq_sn);
    end
  end

  // ---------------------------------------------------------------------
  // stage F: squared limit, limit times lengths, tolerance product
  // ---------------------------------------------------------------------
  logic f_v;
  side_t f_side;
  logic [W2-1:0] f_lim2, f_limr, f_lims, f_lens;
  logic [NW-1:0] f_lensp;
  logic f_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side  <= e_side;
      f_lim2  <= W2'(e_lim) * W2'(e_lim);
      f_limr  <= W2'(e_lim) * W2'(e_rn);
      f_lims  <= W2'(e_lim) * W2'(e_sn);
      f_lensp <= NW'(e_lens) * NW'(par_tol);
      f_lens  <= e_lens;
      f_degen <= (e_lens == '0) || (e_lens < W2'({tiny, {FRAC_BITS{1'b0}}}));
    end
  end

  // ---------------------------------------------------------------------
  // stage G: classify, then divide |r.s| * 2^16 by rn * sn
  // ---------------------------------------------------------------------
  logic close, par;
  ctl_t g_ctl;
  logic [NW-1:0] g_num;

  always_comb begin
    close = near(f_side.tiny_s, f_side.pj[0], f_side.d11, f_side.d12,
                 f_side.crs1, f_lim2, f_lims)
         || near(f_side.tiny_s, f_side.pj[1], f_side.d21, f_side.d22,
                 f_side.crs2, f_lim2, f_lims)
         || near(f_side.tiny_r, f_side.pj[2], f_side.d11, f_side.d21,
                 f_side.crs3, f_lim2, f_limr)
         || near(f_side.tiny_r, f_side.pj[3], f_side.d12, f_side.d22,
                 f_side.crs4, f_lim2, f_limr);
    par   = {f_side.babs, {FRAC_BITS{1'b0}}} <= f_lensp;
    g_num = {f_side.rsabs, {FRAC_BITS{1'b0}}};
    // quotient of 2 or more saturates anyway; the divider covers below that
    g_ctl.sat  = {1'b0, f_side.rsabs} >= {f_lens, 1'b0};
    g_ctl.cls  = CLS_NONE;
    g_ctl.mode = MODE_ZERO;
    if (par) begin
      if (close) begin
        g_ctl.cls  = CLS_PARALLEL;
        g_ctl.mode = MODE_ONE;
      end
    end else if (f_side.cross_ok || close) begin
      if (f_degen) begin
        g_ctl.cls = CLS_DEGEN;
      end else if (f_side.eq[0] || f_side.eq[3]) begin
        g_ctl.cls  = CLS_SHARED;
        g_ctl.mode = f_side.rs_neg ? MODE_NEG : MODE_POS;
      end else if (f_side.eq[1] || f_side.eq[2]) begin
        // endpoints meet head to tail: cosine flips sign
        g_ctl.cls  = CLS_SHARED;
        g_ctl.mode = f_side.rs_neg ? MODE_POS : MODE_NEG;
      end else begin
        g_ctl.cls  = CLS_CROSS;
        g_ctl.mode = MODE_POS;
      end
    end
  end

  logic dv_v;
  logic [QUO_BITS-1:0] dv_q;
  ctl_t dv_ctl;

  sic_div #(
    .NW (NW),
    .DW (W2)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (f_v),
    .num     (g_num),
    .den     (f_lens),
    .ctl_in  (g_ctl),
    .out_v   (dv_v),
    .quo     (dv_q),
    .ctl_out (dv_ctl)
  );

  // ---------------------------------------------------------------------
  // output register: saturate, apply sign
  // ---------------------------------------------------------------------
  logic [QUO_BITS-1:0] cmag;
  logic signed [COS_W-1:0] cos_next;

  assign cmag = (dv_ctl.sat || (dv_q > COS_ONE)) ? COS_ONE : dv_q;

  always_comb begin
    case (dv_ctl.mode)
      MODE_ZERO: cos_next = '0;
      MODE_ONE:  cos_next = $signed({1'b0, COS_ONE});
      MODE_POS:  cos_next = $signed({1'b0, cmag});
      MODE_NEG:  cos_next = -$signed({1'b0, cmag});
      default:   cos_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_class <= dv_ctl.cls;
      cosine       <= cos_next;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_par_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_class == CLS_PARALLEL) |-> cosine == $signed({1'b0, COS_ONE}))
    else $error("parallel-close item without unit cosine");

  a_zero_cos: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((result_class == CLS_NONE) || (result_class == CLS_DEGEN))
    |-> cosine == '0)
    else $error("none or degenerate item with nonzero cosine");

  a_cross_abs: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_class == CLS_CROSS) |-> !cosine[COS_W-1])
    else $error("crossing item with negative cosine");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cosine <= $signed({1'b0, COS_ONE}))
               && (cosine >= -$signed({1'b0, COS_ONE})))
    else $error("cosine out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

/* tb/segment_intersection_cosine_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for segment_intersection_cosine_unit: directed table,
// then randomized segment pairs over several register settings.
// Depends on sic_pkg and the unit itself.
module segment_intersection_cosine_unit_test;
  import sic_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [COS_W-1:0] cos_t;

  typedef struct packed {
    logic signed [31:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
  } seg_pair_t;

  typedef struct packed {
    class_t cls;
    cos_t   cosv;
  } angle_t;

  // directed row: expectation typed in only when 'typed' is set
  typedef struct packed {
    seg_pair_t pair;
    logic      typed;
    angle_t    want;
  } row_t;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam int ITEMS_PER_PHASE = 260;
  localparam int N_PHASES = 5;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  seg_pair_t pair_drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  class_t result_class;
  cos_t cosine;

  // typed expectation riding along with the payload
  logic   dir_typed = 1'b0;
  angle_t dir_want = '0;

  // predictor copy of the registers
  logic [15:0] par_tol_r = PAR_TOL_RST;
  logic [15:0] close_r = CLOSE_RST;
  logic [15:0] tiny_r = TINY_RST;

  angle_t pending_angles[$];
  int errors = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  logic hold_req = 1'b0;
  logic hold_rx = 1'b0;
  logic hold_done = 1'b0;

  segment_intersection_cosine_unit #(.COORD_BITS(32)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .p1_x(pair_drv.p1x), .p1_y(pair_drv.p1y),
    .p2_x(pair_drv.p2x), .p2_y(pair_drv.p2y),
    .q1_x(pair_drv.q1x), .q1_y(pair_drv.q1y),
    .q2_x(pair_drv.q2x), .q2_y(pair_drv.q2y),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_class(result_class), .cosine(cosine)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Exact-integer predictor. All intermediate values fit comfortably in
  // 128 signed bits for 32-bit coordinates.
  // ---------------------------------------------------------------------
  function automatic wide_t mulw(longint a, longint b);
    wide_t aw, bw;
    aw = a;
    bw = b;
    return aw * bw;
  endfunction

  function automatic wide_t sq2(longint x, longint y);
    return mulw(x, x) + mulw(y, y);
  endfunction

  function automatic wide_t crossw(longint ax, longint ay, longint bx, longint by);
    return mulw(ax, by) - mulw(ay, bx);
  endfunction

  function automatic wide_t absw(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // floor square root, bit by bit
  function automatic logic [63:0] isqrt(wide_t x);
    logic [63:0] root, c;
    logic [127:0] cw;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      c = root | (64'd1 << k);
      cw = c;
      if (cw * cw <= $unsigned(x)) root = c;
    end
    return root;
  endfunction

  // is point e within lim of segment a-b
  function automatic logic near_seg(longint ex, longint ey, longint ax, longint ay,
                                    longint bx, longint by, logic [63:0] lim);
    longint dx, dy, fx, fy;
    wide_t len2, lim2, ea, dot, limw, rootw, tinyw;
    dx = bx - ax;
    dy = by - ay;
    fx = ex - ax;
    fy = ey - ay;
    len2 = sq2(dx, dy);
    limw = lim;
    lim2 = limw * limw;
    ea = sq2(fx, fy);
    tinyw = {tiny_r, 16'h0};
    if (len2 <= tinyw) return ea <= lim2;
    dot = mulw(fx, dx) + mulw(fy, dy);
    if (dot >= 0 && dot <= len2) begin
      rootw = isqrt(len2);
      return absw(crossw(fx, fy, dx, dy)) <= limw * rootw;
    end
    return (ea <= lim2) || (sq2(ex - bx, ey - by) <= lim2);
  endfunction

  function automatic logic in_unit(wide_t num, wide_t den);
    if (num == 0) return 1'b1;
    if ((num < 0) != (den < 0)) return 1'b0;
    return absw(num) <= absw(den);
  endfunction

  function automatic angle_t predict_angle(seg_pair_t s);
    longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y, rx, ry, sx, sy, qx, qy;
    logic [63:0] rn, sn, mx, lim;
    wide_t b, lens, rs, quo, c, rnw, snw, tolw, tinyw;
    logic close;
    angle_t a;
    p1x = s.p1x; p1y = s.p1y; p2x = s.p2x; p2y = s.p2y;
    q1x = s.q1x; q1y = s.q1y; q2x = s.q2x; q2y = s.q2y;
    rx = p2x - p1x; ry = p2y - p1y;
    sx = q2x - q1x; sy = q2y - q1y;
    rn = isqrt(sq2(rx, ry));
    sn = isqrt(sq2(sx, sy));
    mx = (rn > sn) ? rn : sn;
    lim = (mx >> 16) * close_r + (((mx & 64'hffff) * close_r) >> 16);
    b = crossw(rx, ry, sx, sy);
    rnw = rn;
    snw = sn;
    lens = rnw * snw;
    tolw = par_tol_r;
    tinyw = {tiny_r, 16'h0};
    close = near_seg(p1x, p1y, q1x, q1y, q2x, q2y, lim)
         || near_seg(p2x, p2y, q1x, q1y, q2x, q2y, lim)
         || near_seg(q1x, q1y, p1x, p1y, p2x, p2y, lim)
         || near_seg(q2x, q2y, p1x, p1y, p2x, p2y, lim);
    a.cls = CLS_NONE;
    a.cosv = '0;
    if ((absw(b) <<< 16) <= lens * tolw) begin
      // nearly parallel: only closeness matters
      if (close) begin
        a.cls = CLS_PARALLEL;
        a.cosv = 18'sd65536;
      end
    end else begin
      qx = q1x - p1x;
      qy = q1y - p1y;
      if ((in_unit(crossw(qx, qy, sx, sy), b) && in_unit(crossw(qx, qy, rx, ry), b))
          || close) begin
        if (lens == 0 || lens < tinyw) begin
          a.cls = CLS_DEGEN;
        end else begin
          rs = mulw(rx, sx) + mulw(ry, sy);
          quo = (absw(rs) <<< 16) / lens;
          c = (quo > 65536) ? 65536 : quo;  // rounded-down lengths can overshoot
          if (rs < 0) c = -c;
          a.cls = CLS_SHARED;
          if (p1x == q1x && p1y == q1y) a.cosv = cos_t'(c);
          else if (p1x == q2x && p1y == q2y) a.cosv = cos_t'(-c);
          else if (p2x == q1x && p2y == q1y) a.cosv = cos_t'(-c);
          else if (p2x == q2x && p2y == q2y) a.cosv = cos_t'(c);
          else begin
            a.cls = CLS_CROSS;
            a.cosv = cos_t'(absw(c));
          end
        end
      end
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, longint want, longint got);
    $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $time);
    errors++;
  endtask

  // input side: every accepted item queues its expected answer
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (dir_typed) pending_angles.push_back(dir_want);
      else pending_angles.push_back(predict_angle(pair_drv));
    end
  end

  // output side: compare against the oldest expectation
  always @(posedge clk) begin
    angle_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("result with nothing pending, class", -1, result_class);
      end else begin
        w = pending_angles.pop_front();
        if (result_class !== w.cls) report_mismatch("result_class", w.cls, result_class);
        if (cosine !== w.cosv) report_mismatch("cosine", w.cosv, cosine);
      end
    end
  end

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    out_stall <= hold_rx || (rx_pct > 0 && $urandom_range(0, 99) < rx_pct);
  end

  always begin
    @(posedge clk);
    if (hold_req && !hold_done) begin
      hold_rx <= 1'b1;
      repeat (300) @(posedge clk);
      hold_rx <= 1'b0;
      hold_done = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PAR_TOL: par_tol_r = value;
      REG_CLOSE:   close_r = value;
      REG_TINY:    tiny_r = value;
      default: ;  // unused index, no register behind it
    endcase
  endtask

  task automatic set_regs(logic [15:0] tol, logic [15:0] ratio, logic [15:0] tiny);
    write_cfg(REG_PAR_TOL, tol);
    write_cfg(REG_CLOSE, ratio);
    write_cfg(REG_TINY, tiny);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(seg_pair_t s, logic typed, angle_t want);
    while (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pair_drv <= s;
    dir_typed <= typed;
    dir_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // wait on the clock first so the last accepted item is already queued
  task automatic drain();
    in_valid <= 1'b0;
    dir_typed <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] q_coord();
    return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
  endfunction

  function automatic logic signed [31:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return SMAX;
      1: return SMIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    logic signed [31:0] rx, ry;
    int k;
    case ($urandom_range(0, 9))
      0, 1: s = {$urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
      2: begin  // raw-unit sizes: degenerate and saturation territory
        s.p1x = $signed($urandom_range(0, 32)) - 16; s.p1y = $signed($urandom_range(0, 32)) - 16;
        s.p2x = $signed($urandom_range(0, 32)) - 16; s.p2y = $signed($urandom_range(0, 32)) - 16;
        s.q1x = $signed($urandom_range(0, 32)) - 16; s.q1y = $signed($urandom_range(0, 32)) - 16;
        s.q2x = $signed($urandom_range(0, 32)) - 16; s.q2y = $signed($urandom_range(0, 32)) - 16;
      end
      3, 4: s = {q_coord(), q_coord(), q_coord(), q_coord(),
                 q_coord(), q_coord(), q_coord(), q_coord()};
      5, 6: begin  // one endpoint of q copied from one of p
        s = {q_coord(), q_coord(), q_coord(), q_coord(),
             q_coord(), q_coord(), q_coord(), q_coord()};
        case ($urandom_range(0, 3))
          0: begin s.q1x = s.p1x; s.q1y = s.p1y; end
          1: begin s.q2x = s.p1x; s.q2y = s.p1y; end
          2: begin s.q1x = s.p2x; s.q1y = s.p2y; end
          default: begin s.q2x = s.p2x; s.q2y = s.p2y; end
        endcase
      end
      7, 8: begin  // parallel or nearly so, offset by a small amount
        rx = q_coord() >>> 2;
        ry = q_coord() >>> 2;
        k = $urandom_range(1, 3);
        s.p1x = q_coord(); s.p1y = q_coord();
        s.p2x = s.p1x + rx; s.p2y = s.p1y + ry;
        s.q1x = s.p1x + ($signed($urandom_range(0, 4096)) - 2048);
        s.q1y = s.p1y + ($signed($urandom_range(0, 4096)) - 2048);
        s.q2x = s.q1x + k * rx + ($signed($urandom_range(0, 16)) - 8);
        s.q2y = s.q1y + k * ry + ($signed($urandom_range(0, 16)) - 8);
      end
      default: s = {edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                    edge_coord(), edge_coord(), edge_coord(), edge_coord()};
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table, default register values
  // ---------------------------------------------------------------------
  row_t dir_rows[$];

  task automatic add_row(seg_pair_t s, logic typed, class_t cls, cos_t cosv);
    row_t r;
    r.pair = s;
    r.typed = typed;
    r.want.cls = cls;
    r.want.cosv = cosv;
    dir_rows.push_back(r);
  endtask

  task automatic build_table();
    // all points at the origin: zero lengths, parallel and close
    add_row('0, 1'b1, CLS_PARALLEL, 18'sd65536);
    // perpendicular cross through the origin
    add_row({-ONE, 32'sd0, ONE, 32'sd0, 32'sd0, -ONE, 32'sd0, ONE}, 1'b1, CLS_CROSS, '0);
    // perpendicular, sharing p1 = q1
    add_row({32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE},
            1'b1, CLS_SHARED, '0);
    // perpendicular and far apart
    add_row({32'sd0, 32'sd0, ONE, 32'sd0, 10 * ONE, 5 * ONE, 10 * ONE, 6 * ONE},
            1'b1, CLS_NONE, '0);
    // parallel and far apart
    add_row({32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 10 * ONE, ONE, 10 * ONE},
            1'b1, CLS_NONE, '0);
    // crossing but below the tiny threshold
    add_row({32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1},
            1'b1, CLS_DEGEN, '0);
    // overlapping collinear segments
    add_row({32'sd0, 32'sd0, 4 * ONE, 32'sd0, ONE, 32'sd0, 2 * ONE, 32'sd0},
            1'b1, CLS_PARALLEL, 18'sd65536);
    // each shared-endpoint ordering, 45 degree angle
    add_row({32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE, ONE}, 1'b0, CLS_NONE, '0);
    add_row({32'sd0, 32'sd0, ONE, 32'sd0, ONE, ONE, 32'sd0, 32'sd0}, 1'b0, CLS_NONE, '0);
    add_row({32'sd0, 32'sd0, ONE, 32'sd0, ONE, 32'sd0, 2 * ONE, ONE}, 1'b0, CLS_NONE, '0);
    add_row({32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, -ONE, ONE, 32'sd0}, 1'b0, CLS_NONE, '0);
    // obtuse crossing: absolute cosine
    add_row({-ONE, 32'sd0, ONE, 32'sd0, ONE, -ONE, -ONE, ONE}, 1'b0, CLS_NONE, '0);
    // near miss within the closeness band
    add_row({32'sd0, 32'sd0, 100 * ONE, 32'sd0, 50 * ONE, ONE / 2, 50 * ONE, 20 * ONE},
            1'b0, CLS_NONE, '0);
    // raw-unit sizes where rounded lengths overshoot the cosine
    add_row({32'sd0, 32'sd0, 32'sd3, 32'sd1, 32'sd0, 32'sd0, 32'sd3, 32'sd2},
            1'b0, CLS_NONE, '0);
    // coordinate extremes
    add_row({SMIN, SMIN, SMAX, SMAX, SMIN, SMAX, SMAX, SMIN}, 1'b0, CLS_NONE, '0);
    add_row({SMAX, SMAX, SMIN, SMIN, SMAX, SMAX, SMAX, SMIN}, 1'b0, CLS_NONE, '0);
    add_row({SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN}, 1'b0, CLS_NONE, '0);
    add_row({SMIN, 32'sd0, SMAX, 32'sd0, 32'sd0, SMIN, 32'sd0, SMAX}, 1'b0, CLS_NONE, '0);
    add_row({-32'sd1, -32'sd1, 32'sd0, SMAX, SMIN, -32'sd1, SMAX, 32'sd0},
            1'b0, CLS_NONE, '0);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int sent;
    angle_t none_want;
    none_want = '0;
    sent = 0;
    build_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender 32% idle, receiver 52% idle for the first stretch
    tx_pct = 32;
    rx_pct = 52;
    foreach (dir_rows[i]) send_item(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // registers change only with the pipeline empty
      case (ph)
        0: begin
          set_regs(PAR_TOL_RST, CLOSE_RST, TINY_RST);
          write_cfg(REG_UNUSED, 16'hffff);
          cfg_valid <= 1'b0;
        end
        1: set_regs(16'hffff, 16'hffff, 16'hffff);
        2: set_regs(16'h0000, 16'h0000, 16'h0000);
        3: set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 3)));
        default: set_regs(16'd1000, 16'd3000, 16'd0);
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (sent == 433) begin
          tx_pct = 52;
          rx_pct = 32;
        end else if (sent == 866) begin
          tx_pct = 0;
          rx_pct = 0;
        end
        // long receiver hold-off while items keep coming
        if (sent == 950) hold_req <= 1'b1;
        send_item(random_pair(), 1'b0, none_want);
        sent++;
      end
      drain();  // sender pauses until every answer is in
    end

    repeat (80) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* segment_intersection_cosine_unit.f */
rtl/core/sic_pkg.sv
rtl/core/sic_isqrt2.sv
rtl/core/sic_div.sv
rtl/core/segment_intersection_cosine_unit.sv
tb/segment_intersection_cosine_unit_test.sv
